// ===== sv/pst_pkg.sv =====
// Shared types and constants for the PMT section parser.
`default_nettype none
package pst_pkg;

   // Status codes carried in the section summary.
   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_TRUNC   = 3'd1;
   localparam logic [2:0] ST_BADHDR  = 3'd2;
   localparam logic [2:0] ST_MULTI   = 3'd3;
   localparam logic [2:0] ST_OVERRUN = 3'd4;
   localparam logic [2:0] ST_TOOMANY = 3'd5;

   localparam logic [7:0] PMT_TABLE_ID = 8'h02;
   localparam logic [9:0] MIN_LENGTH   = 10'd13;
   localparam logic [9:0] MAX_LENGTH   = 10'd1021;

   // Result kind.
   localparam logic KIND_ENTRY   = 1'b0;
   localparam logic KIND_SUMMARY = 1'b1;

   typedef struct packed {
      logic [7:0] section_byte;
      logic       buffer_end;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [12:0] stream_pid;
      logic [7:0]  stream_kind;
      logic [5:0]  entry_index;
      logic [15:0] program_id;
      logic [4:0]  table_version;
      logic        current_next;
      logic [12:0] clock_ref_pid;
      logic [6:0]  entry_total;
      logic [2:0]  status;
      logic        last;
   } rsp_type;

   // One queue record: what a single input byte produced.
   typedef struct packed {
      logic        has_entry;
      logic        has_summary;
      logic [12:0] stream_pid;
      logic [7:0]  stream_kind;
      logic [5:0]  entry_index;
      logic [15:0] program_id;
      logic [4:0]  table_version;
      logic        current_next;
      logic [12:0] clock_ref_pid;
      logic [6:0]  entry_total;
      logic [2:0]  status;
   } rec_type;

endpackage
`default_nettype wire

// ===== sv/pmt_section_parser.sv =====
// PMT section parser: one section byte per transaction in, entries and summary out.
// Throughput: one byte per cycle while the record queue has room; results leave at
// one per cycle while rsp_stall is low; a byte giving both an entry and the summary
// leaves as two transactions from the output register. The accepting edge writes
// the record queue, and rsp_valid rises when the output register loads the record.
// The input stalls only when the record queue between parser and output is full.
// Reset (synchronous): parser back to the header phase, queue and output emptied.
`default_nettype none
module pmt_section_parser
   import pst_pkg::*;
#(
   parameter int MAX_ENTRIES = 32,
   parameter int QUEUE_DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    rec_push;
   rec_type rec_data;
   rec_type head_data;
   logic    q_empty;
   logic    q_full;
   logic    q_pop;

   pst_front #(
      .MAX_ENTRIES(MAX_ENTRIES)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .queue_full(q_full),
      .rec_push  (rec_push),
      .rec_data  (rec_data)
   );

   pst_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (rec_push),
      .push_data(rec_data),
      .pop      (q_pop),
      .head_data(head_data),
      .empty    (q_empty),
      .full     (q_full)
   );

   pst_emit u_emit (
      .clock    (clock),
      .reset    (reset),
      .head_data(head_data),
      .empty    (q_empty),
      .pop      (q_pop),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

endmodule
`default_nettype wire

// ===== sv/pst_front.sv =====
// Byte-level section parser: header checks, descriptor skipping, entry extraction.
`default_nettype none
module pst_front
   import pst_pkg::*;
#(
   parameter int MAX_ENTRIES = 32
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_stall,
   input  wire req_type req_data,
   input  wire logic    queue_full,
   output logic         rec_push,
   output rec_type      rec_data
);

   typedef enum logic [2:0] {
      PH_HEADER,
      PH_PROG_SKIP,
      PH_ES_HEAD,
      PH_ES_SKIP,
      PH_DONE
   } phase_type;

   phase_type   phase_ff, phase_in;
   logic [10:0] pos_ff, pos_in;
   logic [9:0]  dlen_ff, dlen_in;
   logic [11:0] skip_ff, skip_in;
   logic [15:0] prog_ff, prog_in;
   logic [4:0]  ver_ff, ver_in;
   logic        cur_ff, cur_in;
   logic [12:0] pcr_ff, pcr_in;
   logic [31:0] ebytes_ff, ebytes_in;
   logic [2:0]  ecount_ff, ecount_in;
   logic [6:0]  seen_ff, seen_in;
   logic [2:0]  err_ff, err_in;

   logic        accept;
   logic [7:0]  b;
   logic [11:0] nxt;
   logic [9:0]  crc_at;
   logic [11:0] crc_at_w;
   logic        do_latch;
   logic [2:0]  latch_code;
   logic        do_begin;
   logic [11:0] begin_at;
   logic        emit_entry;
   logic [11:0] len;
   logic [11:0] pil;
   logic [11:0] esl;
   logic [11:0] skip_dec;
   logic [2:0]  st;

   assign accept    = req_valid && !queue_full;
   assign req_stall = queue_full;
   assign b         = req_data.section_byte;
   assign nxt       = {1'b0, pos_ff} + 12'd1;
   assign crc_at    = dlen_ff - 10'd1;
   assign crc_at_w  = {2'b00, crc_at};
   assign len       = {ebytes_ff[3:0], b};
   assign pil       = {ebytes_ff[3:0], b};
   assign esl       = {ebytes_ff[3:0], b};
   assign skip_dec  = (skip_ff == 12'd0) ? 12'd0 : skip_ff - 12'd1;

   always_comb begin
      phase_in   = phase_ff;
      dlen_in    = dlen_ff;
      skip_in    = skip_ff;
      prog_in    = prog_ff;
      ver_in     = ver_ff;
      cur_in     = cur_ff;
      pcr_in     = pcr_ff;
      ebytes_in  = ebytes_ff;
      ecount_in  = ecount_ff;
      seen_in    = seen_ff;
      err_in     = err_ff;
      do_latch   = 1'b0;
      latch_code = ST_OK;
      do_begin   = 1'b0;
      begin_at   = 12'd0;
      emit_entry = 1'b0;

      case (phase_ff)
         PH_HEADER: begin
            if (pos_ff == 11'd0 || pos_ff == 11'd1 || pos_ff == 11'd10) begin
               ebytes_in = {ebytes_ff[23:0], b};
            end else if (pos_ff == 11'd2) begin
               // ebytes holds table id and the flags byte
               if (ebytes_ff[15:8] != PMT_TABLE_ID || !ebytes_ff[7]
                   || len[9:0] < MIN_LENGTH || len > {2'b00, MAX_LENGTH}) begin
                  do_latch   = 1'b1;
                  latch_code = ST_BADHDR;
               end else begin
                  dlen_in = len[9:0];
               end
            end else if (pos_ff == 11'd3) begin
               prog_in = {b, 8'h00};
            end else if (pos_ff == 11'd4) begin
               prog_in = {prog_ff[15:8], b};
            end else if (pos_ff == 11'd5) begin
               ver_in = b[5:1];
               cur_in = b[0];
            end else if (pos_ff == 11'd6 || pos_ff == 11'd7) begin
               if (b != 8'd0) begin
                  do_latch   = 1'b1;
                  latch_code = ST_MULTI;
               end
            end else if (pos_ff == 11'd8) begin
               pcr_in = {b[4:0], 8'h00};
            end else if (pos_ff == 11'd9) begin
               pcr_in = {pcr_ff[12:8], b};
            end else if (pos_ff == 11'd11) begin
               if ({1'b0, pil} + 13'd12 > {1'b0, crc_at_w}) begin
                  do_latch   = 1'b1;
                  latch_code = ST_OVERRUN;
               end else if (pil == 12'd0) begin
                  do_begin = 1'b1;
                  begin_at = 12'd12;
               end else begin
                  skip_in  = pil;
                  phase_in = PH_PROG_SKIP;
               end
            end
         end
         PH_PROG_SKIP, PH_ES_SKIP: begin
            skip_in = skip_dec;
            if (skip_dec == 12'd0) begin
               do_begin = 1'b1;
               begin_at = nxt;
            end
         end
         PH_ES_HEAD: begin
            if (ecount_ff < 3'd4) begin
               ebytes_in = {ebytes_ff[23:0], b};
               ecount_in = ecount_ff + 3'd1;
            end else if ({1'b0, nxt} + {1'b0, esl} > {1'b0, crc_at_w}) begin
               do_latch   = 1'b1;
               latch_code = ST_OVERRUN;
            end else if (seen_ff >= 7'(MAX_ENTRIES)) begin
               do_latch   = 1'b1;
               latch_code = ST_TOOMANY;
            end else begin
               emit_entry = 1'b1;
               seen_in    = seen_ff + 7'd1;
               if (esl == 12'd0) begin
                  do_begin = 1'b1;
                  begin_at = nxt;
               end else begin
                  skip_in  = esl;
                  phase_in = PH_ES_SKIP;
               end
            end
         end
         default: begin
         end
      endcase

      // entry loop start: the CRC begins at length - 1
      if (do_begin) begin
         if (begin_at >= crc_at_w) begin
            phase_in = PH_DONE;
         end else if (crc_at_w - begin_at < 12'd5) begin
            do_latch   = 1'b1;
            latch_code = ST_OVERRUN;
         end else begin
            phase_in  = PH_ES_HEAD;
            ecount_in = 3'd0;
            ebytes_in = 32'd0;
         end
      end

      if (do_latch) begin
         if (err_ff == ST_OK) begin
            err_in = latch_code;
         end
         phase_in = PH_DONE;
      end

      pos_in = (&pos_ff) ? pos_ff : pos_ff + 11'd1;

      st = err_in;
      if (st != ST_BADHDR && (pos_ff < 11'd2 || nxt < {2'b00, dlen_in} + 12'd3)) begin
         st = ST_TRUNC;
      end
   end

   always_comb begin
      rec_push              = accept && (emit_entry || req_data.buffer_end);
      rec_data.has_entry    = emit_entry;
      rec_data.has_summary  = req_data.buffer_end;
      rec_data.stream_pid   = {ebytes_ff[20:16], ebytes_ff[15:8]};
      rec_data.stream_kind  = ebytes_ff[31:24];
      rec_data.entry_index  = seen_ff[5:0];
      rec_data.program_id   = prog_in;
      rec_data.table_version = ver_in;
      rec_data.current_next = cur_in;
      rec_data.clock_ref_pid = pcr_in;
      rec_data.entry_total  = seen_in;
      rec_data.status       = st;
   end

   always_ff @(posedge clock) begin
      if (reset || (accept && req_data.buffer_end)) begin
         phase_ff  <= PH_HEADER;
         pos_ff    <= 11'd0;
         dlen_ff   <= 10'd0;
         skip_ff   <= 12'd0;
         prog_ff   <= 16'd0;
         ver_ff    <= 5'd0;
         cur_ff    <= 1'b0;
         pcr_ff    <= 13'd0;
         ebytes_ff <= 32'd0;
         ecount_ff <= 3'd0;
         seen_ff   <= 7'd0;
         err_ff    <= ST_OK;
      end else if (accept) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         dlen_ff   <= dlen_in;
         skip_ff   <= skip_in;
         prog_ff   <= prog_in;
         ver_ff    <= ver_in;
         cur_ff    <= cur_in;
         pcr_ff    <= pcr_in;
         ebytes_ff <= ebytes_in;
         ecount_ff <= ecount_in;
         seen_ff   <= seen_in;
         err_ff    <= err_in;
      end
   end

endmodule
`default_nettype wire

// ===== sv/pst_queue.sv =====
// Small FIFO of parser records between the front and the output stage.
`default_nettype none
module pst_queue
   import pst_pkg::*;
#(
   parameter int DEPTH = 4
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push,
   input  wire rec_type push_data,
   input  wire logic    pop,
   output rec_type      head_data,
   output logic         empty,
   output logic         full
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   rec_type         mem [DEPTH];
   logic [PW-1:0]   wr_ptr_ff;
   logic [PW-1:0]   rd_ptr_ff;
   logic [CW-1:0]   count_ff;

   assign empty     = (count_ff == CW'(0));
   assign full      = (count_ff == CW'(DEPTH));
   assign head_data = mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
         end
         if (push && !pop) begin
            count_ff <= count_ff + CW'(1);
         end else if (pop && !push) begin
            count_ff <= count_ff - CW'(1);
         end
      end
   end

endmodule
`default_nettype wire

// ===== sv/pst_emit.sv =====
// Output stage: expands queue records into entry and summary transactions.
`default_nettype none
module pst_emit
   import pst_pkg::*;
(
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire rec_type head_data,
   input  wire logic    empty,
   output logic         pop,
   output logic         rsp_valid,
   input  wire logic    rsp_stall,
   output rsp_type      rsp_data
);

   logic    rsp_valid_ff;
   rsp_type rsp_data_ff, rsp_data_in;
   logic    entry_sent_ff;
   logic    load;
   logic    send_entry;

   assign load       = !rsp_valid_ff || !rsp_stall;
   assign send_entry = head_data.has_entry && !entry_sent_ff;
   // a record holding entry and summary stays at the head for a second transaction
   assign pop        = load && !empty && !(send_entry && head_data.has_summary);
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;

   always_comb begin
      rsp_data_in = '0;
      if (send_entry) begin
         rsp_data_in.kind        = KIND_ENTRY;
         rsp_data_in.stream_pid  = head_data.stream_pid;
         rsp_data_in.stream_kind = head_data.stream_kind;
         rsp_data_in.entry_index = head_data.entry_index;
      end else begin
         rsp_data_in.kind          = KIND_SUMMARY;
         rsp_data_in.program_id    = head_data.program_id;
         rsp_data_in.table_version = head_data.table_version;
         rsp_data_in.current_next  = head_data.current_next;
         rsp_data_in.clock_ref_pid = head_data.clock_ref_pid;
         rsp_data_in.entry_total   = head_data.entry_total;
         rsp_data_in.status        = head_data.status;
         rsp_data_in.last          = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         entry_sent_ff <= 1'b0;
      end else if (load) begin
         rsp_valid_ff <= !empty;
         if (!empty) begin
            entry_sent_ff <= send_entry && head_data.has_summary;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load && !empty) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

endmodule
`default_nettype wire

// ===== test/tb_pmt_section_parser.sv =====
// Testbench for pmt_section_parser: section byte stimulus, PMT parse prediction and result checks.
`timescale 1ns / 1ps

module tb_pmt_section_parser;
   import pst_pkg::*;

   localparam int ENTRY_LIMIT         = 32;
   localparam int ITEM_TARGET         = 700;
   localparam int MIN_RANDOM_SECTIONS = 3;
   localparam int DRAIN_CYCLES        = 8;
   localparam int HOLD_CYCLES         = 200;
   localparam longint LIMIT_NS        = 10_000_000;

   typedef enum logic [2:0] {
      PH_HEADER, PH_PROG_SKIP, PH_ES_HEAD, PH_ES_SKIP, PH_DONE
   } parse_phase_type;

   logic    clock     = 1'b0;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   pmt_section_parser dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #(LIMIT_NS);
      $display("TEST FAILED");
      $finish;
   end

   // Parser state mirrored by the predictor
   int              byte_idx;
   int              sect_len;
   parse_phase_type phase;
   int              skip_left;
   logic [15:0]     prog_num;
   logic [4:0]      version;
   logic            cur_next;
   logic [12:0]     pcr_pid;
   logic [31:0]     shift_reg;
   int              head_count;
   int              entry_count;
   logic [2:0]      err_status;

   rsp_type      pmt_results_due[$];
   logic [7:0]   section_buf[$];

   bit idle_enable  = 1'b1;
   int hold_request = 0;
   int error_count  = 0;
   int buffers_sent = 0;
   int items_sent   = 0;
   int parsed_bytes = 0;
   int entries_checked = 0;
   int summaries_checked = 0;
   int input_stall_cycles = 0;
   int status_hits[6];

   task automatic clear_parser();
      byte_idx    = 0;
      sect_len    = 0;
      phase       = PH_HEADER;
      skip_left   = 0;
      prog_num    = '0;
      version     = '0;
      cur_next    = 1'b0;
      pcr_pid     = '0;
      shift_reg   = '0;
      head_count  = 0;
      entry_count = 0;
      err_status  = ST_OK;
   endtask

   task automatic latch_status(input logic [2:0] code);
      if (err_status == ST_OK)
         err_status = code;
      phase = PH_DONE;
   endtask

   // CRC starts at offset sect_len - 1; an entry header needs five bytes before it
   task automatic open_entry_loop(input int nxt);
      int crc_at;
      crc_at = sect_len - 1;
      if (nxt >= crc_at)
         phase = PH_DONE;
      else if (crc_at - nxt < 5)
         latch_status(ST_OVERRUN);
      else begin
         phase      = PH_ES_HEAD;
         head_count = 0;
         shift_reg  = '0;
      end
   endtask

   task automatic predict_section_byte(input logic [7:0] b, input logic last_byte);
      int         idx, nxt, len, pil, esl;
      logic [2:0] st;
      rsp_type    r;
      idx = byte_idx;
      nxt = idx + 1;
      if (phase != PH_DONE)
         parsed_bytes++;
      case (phase)
         PH_HEADER: begin
            case (idx)
               0, 1, 10: shift_reg = {shift_reg[23:0], b};
               2: begin
                  len = int'({shift_reg[3:0], b});
                  if (shift_reg[15:8] != PMT_TABLE_ID || !shift_reg[7] ||
                      len < int'(MIN_LENGTH) || len > int'(MAX_LENGTH))
                     latch_status(ST_BADHDR);
                  else
                     sect_len = len;
               end
               3: prog_num = {b, 8'h00};
               4: prog_num[7:0] = b;
               5: begin
                  version  = b[5:1];
                  cur_next = b[0];
               end
               6, 7: if (b != 8'h00) latch_status(ST_MULTI);
               8: pcr_pid = {b[4:0], 8'h00};
               9: pcr_pid[7:0] = b;
               11: begin
                  pil = int'({shift_reg[3:0], b});
                  if (12 + pil > sect_len - 1)
                     latch_status(ST_OVERRUN);
                  else if (pil == 0)
                     open_entry_loop(12);
                  else begin
                     skip_left = pil;
                     phase     = PH_PROG_SKIP;
                  end
               end
               default: ;
            endcase
         end
         PH_PROG_SKIP, PH_ES_SKIP: begin
            if (skip_left > 0)
               skip_left--;
            if (skip_left == 0)
               open_entry_loop(nxt);
         end
         PH_ES_HEAD: begin
            if (head_count < 4) begin
               shift_reg = {shift_reg[23:0], b};
               head_count++;
            end else begin
               esl = int'({shift_reg[3:0], b});
               if (nxt + esl > sect_len - 1)
                  latch_status(ST_OVERRUN);
               else if (entry_count >= ENTRY_LIMIT)
                  latch_status(ST_TOOMANY);
               else begin
                  r             = '0;
                  r.kind        = KIND_ENTRY;
                  r.stream_pid  = {shift_reg[20:16], shift_reg[15:8]};
                  r.stream_kind = shift_reg[31:24];
                  r.entry_index = 6'(entry_count);
                  pmt_results_due.push_back(r);
                  entry_count++;
                  if (esl == 0)
                     open_entry_loop(nxt);
                  else begin
                     skip_left = esl;
                     phase     = PH_ES_SKIP;
                  end
               end
            end
         end
         default: ;
      endcase
      byte_idx = (nxt > 2047) ? 2047 : nxt;
      if (last_byte) begin
         // truncation overrides every status but a bad header
         st = err_status;
         if (st != ST_BADHDR && (idx < 2 || nxt < sect_len + 3))
            st = ST_TRUNC;
         r               = '0;
         r.kind          = KIND_SUMMARY;
         r.program_id    = prog_num;
         r.table_version = version;
         r.current_next  = cur_next;
         r.clock_ref_pid = pcr_pid;
         r.entry_total   = 7'(entry_count);
         r.status        = st;
         r.last          = 1'b1;
         pmt_results_due.push_back(r);
         clear_parser();
      end
   endtask

   task automatic report_mismatch(input string name, input logic [15:0] want,
                                  input logic [15:0] got);
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      error_count++;
   endtask

   task automatic check_result(input rsp_type got);
      rsp_type want;
      if (pmt_results_due.size() == 0) begin
         $error("result with nothing outstanding: kind %0d status %0d", got.kind, got.status);
         error_count++;
      end else begin
         want = pmt_results_due.pop_front();
         if (got.kind !== want.kind)
            report_mismatch("kind", 16'(want.kind), 16'(got.kind));
         if (got.stream_pid !== want.stream_pid)
            report_mismatch("stream_pid", 16'(want.stream_pid), 16'(got.stream_pid));
         if (got.stream_kind !== want.stream_kind)
            report_mismatch("stream_kind", 16'(want.stream_kind), 16'(got.stream_kind));
         if (got.entry_index !== want.entry_index)
            report_mismatch("entry_index", 16'(want.entry_index), 16'(got.entry_index));
         if (got.program_id !== want.program_id)
            report_mismatch("program_id", want.program_id, got.program_id);
         if (got.table_version !== want.table_version)
            report_mismatch("table_version", 16'(want.table_version),
                            16'(got.table_version));
         if (got.current_next !== want.current_next)
            report_mismatch("current_next", 16'(want.current_next), 16'(got.current_next));
         if (got.clock_ref_pid !== want.clock_ref_pid)
            report_mismatch("clock_ref_pid", 16'(want.clock_ref_pid),
                            16'(got.clock_ref_pid));
         if (got.entry_total !== want.entry_total)
            report_mismatch("entry_total", 16'(want.entry_total), 16'(got.entry_total));
         if (got.status !== want.status)
            report_mismatch("status", 16'(want.status), 16'(got.status));
         if (got.last !== want.last)
            report_mismatch("last", 16'(want.last), 16'(got.last));
         if (want.kind == KIND_SUMMARY) begin
            summaries_checked++;
            status_hits[want.status]++;
         end else
            entries_checked++;
      end
   endtask

   // Results are checked before the byte of the same edge is predicted
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && !rsp_stall)
            check_result(rsp_data);
         if (req_valid && !req_stall)
            predict_section_byte(req_data.section_byte, req_data.buffer_end);
         if (req_valid && req_stall)
            input_stall_cycles++;
      end
   end

   // Receiver: random stalls, or a counted hold-off when one is requested
   initial begin
      int hold_left;
      hold_left = 0;
      forever begin
         @(posedge clock);
         if (hold_request != 0) begin
            hold_left    = hold_request;
            hold_request = 0;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else
            rsp_stall <= idle_enable && ($urandom_range(0, 99) < 31);
      end
   end

   task automatic send_byte(input logic [7:0] b, input logic last_byte);
      req_data  <= {b, last_byte};
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      items_sent++;
      if (idle_enable && $urandom_range(0, 99) < 31) begin
         req_valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(0, 99) < 31)
            @(posedge clock);
      end
   endtask

   // Sends count bytes of the buffer; bytes past its end are random filler
   task automatic send_section(input int count);
      logic [7:0] b;
      for (int i = 0; i < count; i++) begin
         b = (i < section_buf.size()) ? section_buf[i] : 8'($urandom);
         send_byte(b, i == count - 1);
      end
      buffers_sent++;
   endtask

   task automatic set_length(input logic [11:0] len);
      section_buf[1] = {section_buf[1][7:4], len[11:8]};
      section_buf[2] = len[7:0];
   endtask

   // Well-formed PMT section; stray bytes sit between the last entry and the CRC
   task automatic build_section(input int n_es, input int desc_max, input int prog_desc,
                                input int stray);
      int dl;
      section_buf.delete();
      section_buf.push_back(PMT_TABLE_ID);
      section_buf.push_back(8'h00);
      section_buf.push_back(8'h00);
      repeat (3) section_buf.push_back(8'($urandom));
      section_buf.push_back(8'h00);
      section_buf.push_back(8'h00);
      repeat (2) section_buf.push_back(8'($urandom));
      section_buf.push_back({4'($urandom), 4'(prog_desc >> 8)});
      section_buf.push_back(8'(prog_desc));
      repeat (prog_desc) section_buf.push_back(8'($urandom));
      repeat (n_es) begin
         dl = $urandom_range(0, desc_max);
         repeat (3) section_buf.push_back(8'($urandom));
         section_buf.push_back({4'($urandom), 4'(dl >> 8)});
         section_buf.push_back(8'(dl));
         repeat (dl) section_buf.push_back(8'($urandom));
      end
      repeat (stray + 4) section_buf.push_back(8'($urandom));
      set_length(12'(section_buf.size() - 3));
      section_buf[1] = {1'b1, 3'($urandom), section_buf[1][3:0]};
   endtask

   task automatic test_field_extremes();
      logic [7:0] fill;
      build_section(0, 0, 0, 0);
      send_section(section_buf.size());
      // largest legal length passes the header check; the buffer stops early
      build_section(0, 0, 0, 0);
      set_length(12'd1021);
      send_section(14);
      for (int v = 0; v < 2; v++) begin
         fill = v ? 8'hFF : 8'h00;
         build_section(2, 0, 0, 0);
         section_buf[3]  = fill;
         section_buf[4]  = fill;
         section_buf[5]  = fill;
         section_buf[8]  = fill;
         section_buf[9]  = fill;
         section_buf[12] = fill;
         section_buf[13] = fill;
         section_buf[14] = fill;
         section_buf[17] = ~fill;
         section_buf[18] = ~fill;
         section_buf[19] = ~fill;
         send_section(section_buf.size());
      end
   endtask

   task automatic test_header_errors();
      build_section(0, 0, 0, 0);
      section_buf[0] = 8'hFF;
      send_section(section_buf.size());
      build_section(0, 0, 0, 0);
      section_buf[1] = section_buf[1] & 8'h7F;
      send_section(section_buf.size());
      build_section(0, 0, 0, 0);
      set_length(12'd12);
      send_section(section_buf.size());
      set_length(12'd1022);
      send_section(section_buf.size());
      set_length(12'hFFF);
      send_section(section_buf.size());
      build_section(0, 0, 0, 0);
      section_buf[6] = 8'h01;
      send_section(section_buf.size());
      build_section(0, 0, 0, 0);
      section_buf[7] = 8'h80;
      send_section(section_buf.size());
      // bad header on a buffer that also ends at the length byte
      build_section(0, 0, 0, 0);
      section_buf[0] = 8'h42;
      send_section(3);
   endtask

   task automatic test_truncation();
      build_section(2, 2, 3, 0);
      send_section(1);
      send_section(2);
      send_section(3);
      send_section(14);
      send_section(section_buf.size() - 1);
      // buffer ends on the last header byte of an entry: entry then summary
      build_section(2, 0, 0, 0);
      send_section(17);
   endtask

   task automatic test_overruns();
      build_section(1, 0, 0, 0);
      section_buf[10] = 8'h0F;
      send_section(section_buf.size());
      build_section(0, 0, 5, 0);
      send_section(section_buf.size());
      build_section(1, 0, 0, 3);
      send_section(section_buf.size());
      build_section(2, 0, 0, 0);
      section_buf[15] = 8'hFF;
      send_section(section_buf.size());
      // overrun latched, then the buffer is cut short
      send_section(19);
   endtask

   // the last entry allowed is emitted, the one after it is refused
   task automatic test_too_many_streams();
      build_section(ENTRY_LIMIT + 1, 0, 0, 0);
      send_section(section_buf.size());
   endtask

   task automatic test_trailing_bytes();
      build_section(2, 1, 0, 0);
      send_section(section_buf.size() + 3);
   endtask

   task automatic test_back_to_back();
      idle_enable = 1'b0;
      repeat (3) begin
         build_section($urandom_range(0, 4), $urandom_range(0, 3), $urandom_range(0, 4), 0);
         send_section(section_buf.size());
      end
      idle_enable = 1'b1;
   endtask

   task automatic test_output_backpressure();
      idle_enable  = 1'b0;
      hold_request = HOLD_CYCLES;
      build_section(12, 0, 0, 0);
      send_section(section_buf.size());
      idle_enable = 1'b1;
   endtask

   task automatic test_random_sections();
      int sel, sec_size, sections;
      sections = 0;
      while (items_sent < ITEM_TARGET || sections < MIN_RANDOM_SECTIONS) begin
         sel = $urandom_range(0, 99);
         if (sel < 3)
            build_section($urandom_range(30, 36), 1, 0, 0);
         else
            build_section($urandom_range(0, 4), $urandom_range(0, 3),
                          ($urandom_range(0, 3) == 0) ? $urandom_range(1, 6) : 0,
                          ($urandom_range(0, 9) == 0) ? $urandom_range(1, 6) : 0);
         sec_size = section_buf.size();
         if (sel < 70)
            send_section(sec_size + (($urandom_range(0, 4) == 0) ? $urandom_range(1, 3) : 0));
         else if (sel < 80)
            send_section($urandom_range(1, sec_size - 1));
         else if (sel < 88) begin
            section_buf[$urandom_range(0, 11)] = 8'($urandom);
            send_section(sec_size);
         end else if (sel < 94) begin
            set_length(12'($urandom_range(0, 80)));
            send_section(sec_size);
         end else begin
            section_buf.delete();
            repeat ($urandom_range(1, 24)) section_buf.push_back(8'($urandom));
            send_section(section_buf.size());
         end
         sections++;
      end
   endtask

   initial begin
      clear_parser();
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_field_extremes();
      test_header_errors();
      test_truncation();
      test_overruns();
      test_too_many_streams();
      test_trailing_bytes();
      test_back_to_back();
      test_output_backpressure();
      test_random_sections();

      req_valid <= 1'b0;
      @(posedge clock);
      while (pmt_results_due.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d buffers, %0d bytes sent, %0d parsed, %0d entries,",
               buffers_sent, items_sent, parsed_bytes, entries_checked);
      $display("%0d summaries, %0d input stall cycles; status ok %0d, truncated %0d,",
               summaries_checked, input_stall_cycles, status_hits[ST_OK],
               status_hits[ST_TRUNC]);
      $display("bad header %0d, multi %0d, overrun %0d, too many %0d",
               status_hits[ST_BADHDR], status_hits[ST_MULTI], status_hits[ST_OVERRUN],
               status_hits[ST_TOOMANY]);
      if (error_count == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// ===== files.f =====
sv/pst_pkg.sv
sv/pst_front.sv
sv/pst_queue.sv
sv/pst_emit.sv
sv/pmt_section_parser.sv
test/tb_pmt_section_parser.sv
